FILE: rtl/srsa_pkg.sv
`timescale 1ns / 1ps
package srsa_pkg;

	localparam int ROWS          = 1024;
	localparam int SLOTS         = 16;
	localparam int ROW_AW        = $clog2(ROWS);
	localparam int SLOT_AW       = $clog2(SLOTS);
	localparam int FILL_W        = $clog2(SLOTS + 1);
	localparam int ENT_AW        = $clog2(ROWS * SLOTS);
	localparam int COL_W         = 10;
	localparam int VAL_W         = 32;
	localparam int ENT_W         = COL_W + VAL_W;
	localparam int NZ_W          = 15;
	localparam int BW_W          = 5;
	localparam logic [NZ_W-1:0] NZ_MAX   = {NZ_W{1'b1}};
	localparam logic [BW_W-1:0] BW_RESET = BW_W'(16);

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STS_ACCUMULATED = 3'd0,
		STS_APPENDED    = 3'd1,
		STS_UPPER       = 3'd2,
		STS_DROPPED     = 3'd3,
		STS_READ_OK     = 3'd4,
		STS_READ_EMPTY  = 3'd5,
		STS_CLEARED     = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		RK_CLEAR,
		RK_UPPER,
		RK_DROP,
		RK_EMPTY,
		RK_READ,
		RK_ACC,
		RK_APPEND
	} res_kind_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_FILL_RD,
		S_FILL_LAT,
		S_DISPATCH,
		S_SEARCH,
		S_ACC,
		S_ENT_RD,
		S_ENT_WAIT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic      load_item;
		logic      sweep_start;
		logic      sweep_step;
		logic      fill_rd;
		logic      fill_latch;
		logic      search_start;
		logic      search_step;
		logic      ent_rd;
		logic      acc_latch;
		logic      acc_write;
		logic      append_write;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_push;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       in_range;
		logic       upper;
		logic       slot_ok;
		logic       row_full;
		logic       match;
		logic       search_done;
		logic       sweep_last;
		logic       out_free;
	} dp_sts_t;

	// signed add that clamps to the 32-bit range
	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] s;
		s = a + b;
		if ((a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1])) begin
			s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

FILE: rtl/srsa_ram.sv
`timescale 1ns / 1ps
module srsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/srsa_ctrl.sv
`timescale 1ns / 1ps
module srsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [1:0]        in_cmd,
	output logic              s_tready,
	input  srsa_pkg::dp_sts_t sts,
	output srsa_pkg::dp_cmd_t cmd
);

	import srsa_pkg::*;

	state_t state_q, state_d;
	logic   reply_q;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_cmd == CMD_CLEAR) begin
				reply_q <= 1'b1;
			end else if (state_q == S_SWEEP && sts.sweep_last) begin
				reply_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sts.sweep_last) begin
					state_d = reply_q ? S_RESULT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_CLEAR) begin
						state_d = S_SWEEP;
					end else if (in_cmd == CMD_INSERT || in_cmd == CMD_READ) begin
						state_d = S_FILL_RD;
					end
				end
			end
			S_FILL_RD:  state_d = S_FILL_LAT;
			S_FILL_LAT: state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (sts.cmd == CMD_INSERT) begin
					state_d = (!sts.in_range || sts.upper) ? S_RESULT : S_SEARCH;
				end else begin
					state_d = (sts.in_range && sts.slot_ok) ? S_ENT_RD : S_RESULT;
				end
			end
			S_SEARCH: begin
				if (sts.match) begin
					state_d = S_ACC;
				end else if (sts.search_done) begin
					state_d = S_RESULT;
				end
			end
			S_ACC:      state_d = S_RESULT;
			S_ENT_RD:   state_d = S_ENT_WAIT;
			S_ENT_WAIT: state_d = S_RESULT;
			S_RESULT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load_item = accept;
		unique case (state_q)
			S_SWEEP: cmd.sweep_step = 1'b1;
			S_IDLE: begin
				if (accept && in_cmd == CMD_CLEAR) begin
					cmd.sweep_start = 1'b1;
					cmd.res_load    = 1'b1;
					cmd.res_kind    = RK_CLEAR;
				end
			end
			S_FILL_RD:  cmd.fill_rd = 1'b1;
			S_FILL_LAT: cmd.fill_latch = 1'b1;
			S_DISPATCH: begin
				if (sts.cmd == CMD_INSERT) begin
					if (!sts.in_range) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RK_DROP;
					end else if (sts.upper) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RK_UPPER;
					end else begin
						cmd.search_start = 1'b1;
					end
				end else if (!(sts.in_range && sts.slot_ok)) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RK_EMPTY;
				end
			end
			S_SEARCH: begin
				if (sts.match) begin
					cmd.acc_latch = 1'b1;
				end else if (sts.search_done) begin
					cmd.res_load = 1'b1;
					if (sts.row_full) begin
						cmd.res_kind = RK_DROP;
					end else begin
						cmd.append_write = 1'b1;
						cmd.res_kind     = RK_APPEND;
					end
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_ACC: begin
				cmd.acc_write = 1'b1;
				cmd.res_load  = 1'b1;
				cmd.res_kind  = RK_ACC;
			end
			S_ENT_RD:   cmd.ent_rd = 1'b1;
			S_ENT_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RK_READ;
			end
			S_RESULT:   cmd.out_push = sts.out_free;
			default:    cmd.out_push = 1'b0;
		endcase
	end

endmodule

FILE: rtl/srsa_dpath.sv
`timescale 1ns / 1ps
module srsa_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [55:0]       s_tdata,    // row_index, col_index, add_value, slot_index
	input  logic [1:0]        s_tuser,    // cmd
	input  logic              cfg_we,
	input  logic [4:0]        cfg_wdata,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [63:0]       m_tdata,    // entry_col, entry_value, row_entries, total_nonzero
	output logic [3:0]        m_tuser,    // status, over_bandwidth
	input  srsa_pkg::dp_cmd_t cmd,
	output srsa_pkg::dp_sts_t sts
);

	import srsa_pkg::*;

	// item registers
	logic [1:0]        cmd_q;
	logic [9:0]        row_q;
	logic [COL_W-1:0]  col_q;
	logic [VAL_W-1:0]  add_q;
	logic [3:0]        slot_q;

	logic [BW_W-1:0]   bw_q;
	logic [FILL_W-1:0] fill_q;
	logic [ROW_AW-1:0] sweep_q;
	logic [FILL_W-1:0] rd_idx_q;
	logic              pend_q;
	logic [SLOT_AW-1:0] pend_idx_q;
	logic [SLOT_AW-1:0] acc_idx_q;
	logic [VAL_W-1:0]  acc_val_q;
	logic [NZ_W-1:0]   nz_q;

	logic [2:0]        res_status_q;
	logic              res_ob_q;
	logic [COL_W-1:0]  res_col_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [FILL_W-1:0] res_fill_q;
	logic [NZ_W-1:0]   res_nz_q;

	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic              out_ob_q;
	logic [COL_W-1:0]  out_col_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [FILL_W-1:0] out_fill_q;
	logic [NZ_W-1:0]   out_nz_q;

	logic [2:0]        res_status_d;
	logic              res_ob_d;
	logic [COL_W-1:0]  res_col_d;
	logic [VAL_W-1:0]  res_val_d;
	logic [FILL_W-1:0] res_fill_d;
	logic [NZ_W-1:0]   res_nz_d;

	logic [ROW_AW-1:0] row_addr;
	logic              in_range;
	logic [ENT_AW-1:0] ent_base;
	logic              issue;
	logic [VAL_W-1:0]  sum;
	logic [NZ_W-1:0]   nz_next;
	logic [FILL_W-1:0] fill_inc;

	logic              fill_we;
	logic [ROW_AW-1:0] fill_waddr;
	logic [FILL_W-1:0] fill_wdata;
	logic [FILL_W-1:0] fill_rdata;

	logic              ent_we;
	logic [ENT_AW-1:0] ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic              ent_re;
	logic [ENT_AW-1:0] ent_raddr;
	logic [ENT_W-1:0]  ent_rdata;

	assign row_addr = row_q[ROW_AW-1:0];
	assign in_range = 32'(row_q) < ROWS;
	assign ent_base = ENT_AW'(row_addr) * ENT_AW'(SLOTS);
	assign issue    = cmd.search_step && (rd_idx_q < fill_q);
	assign sum      = sat_add(acc_val_q, add_q);
	assign nz_next  = (nz_q != NZ_MAX) ? nz_q + 1'b1 : nz_q;
	assign fill_inc = fill_q + 1'b1;

	// row fill counts: swept to zero after reset and on a clear
	assign fill_we    = cmd.sweep_step || cmd.append_write;
	assign fill_waddr = cmd.sweep_step ? sweep_q : row_addr;
	assign fill_wdata = cmd.sweep_step ? '0 : fill_inc;

	srsa_ram #(
		.WIDTH (FILL_W),
		.DEPTH (ROWS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (cmd.fill_rd),
		.raddr (row_addr),
		.rdata (fill_rdata)
	);

	// entry store, column id above value
	assign ent_we    = cmd.acc_write || cmd.append_write;
	assign ent_waddr = ent_base + (cmd.acc_write ? ENT_AW'(acc_idx_q)
		: ENT_AW'(fill_q[SLOT_AW-1:0]));
	assign ent_wdata = {col_q, cmd.acc_write ? sum : add_q};
	assign ent_re    = cmd.ent_rd || issue;
	assign ent_raddr = ent_base + (cmd.ent_rd ? ENT_AW'(slot_q)
		: ENT_AW'(rd_idx_q[SLOT_AW-1:0]));

	srsa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ROWS * SLOTS)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= s_tuser;
			row_q  <= s_tdata[9:0];
			col_q  <= s_tdata[19:10];
			add_q  <= s_tdata[51:20];
			slot_q <= s_tdata[55:52];
		end
		if (cmd.fill_latch) begin
			fill_q <= in_range ? fill_rdata : '0;
		end
		if (cmd.search_step) begin
			pend_idx_q <= rd_idx_q[SLOT_AW-1:0];
		end
		if (cmd.acc_latch) begin
			acc_idx_q <= pend_idx_q;
			acc_val_q <= ent_rdata[VAL_W-1:0];
		end
		if (cmd.res_load) begin
			res_status_q <= res_status_d;
			res_ob_q     <= res_ob_d;
			res_col_q    <= res_col_d;
			res_val_q    <= res_val_d;
			res_fill_q   <= res_fill_d;
			res_nz_q     <= res_nz_d;
		end
		if (cmd.out_push) begin
			out_status_q <= res_status_q;
			out_ob_q     <= res_ob_q;
			out_col_q    <= res_col_q;
			out_val_q    <= res_val_q;
			out_fill_q   <= res_fill_q;
			out_nz_q     <= res_nz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q        <= BW_RESET;
			sweep_q     <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			nz_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bw_q <= cfg_wdata;
			end
			if (cmd.sweep_start) begin
				sweep_q <= '0;
			end else if (cmd.sweep_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			// issue one slot read a cycle, compare it the cycle after
			if (cmd.search_start) begin
				rd_idx_q <= '0;
				pend_q   <= 1'b0;
			end else if (cmd.search_step) begin
				pend_q <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (cmd.sweep_start) begin
				nz_q <= '0;
			end else if (cmd.append_write) begin
				nz_q <= nz_next;
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_status_d = STS_CLEARED;
		res_ob_d     = 1'b0;
		res_col_d    = '0;
		res_val_d    = '0;
		res_fill_d   = fill_q;
		res_nz_d     = nz_q;
		unique case (cmd.res_kind)
			RK_CLEAR: begin
				res_fill_d = '0;
				res_nz_d   = '0;
			end
			RK_UPPER: res_status_d = STS_UPPER;
			RK_DROP:  res_status_d = STS_DROPPED;
			RK_EMPTY: res_status_d = STS_READ_EMPTY;
			RK_READ: begin
				res_status_d = STS_READ_OK;
				res_col_d    = ent_rdata[ENT_W-1:VAL_W];
				res_val_d    = ent_rdata[VAL_W-1:0];
			end
			RK_ACC: begin
				res_status_d = STS_ACCUMULATED;
				res_col_d    = col_q;
				res_val_d    = sum;
			end
			RK_APPEND: begin
				res_status_d = STS_APPENDED;
				res_ob_d     = fill_q > bw_q;
				res_col_d    = col_q;
				res_val_d    = add_q;
				res_fill_d   = fill_inc;
				res_nz_d     = nz_next;
			end
			default: res_status_d = STS_CLEARED;
		endcase
	end

	assign sts.cmd         = cmd_q;
	assign sts.in_range    = in_range;
	assign sts.upper       = row_q < col_q;
	assign sts.slot_ok     = (FILL_W'(slot_q) < fill_q) && (32'(slot_q) < SLOTS);
	assign sts.row_full    = 32'(fill_q) >= SLOTS;
	assign sts.match       = pend_q && (ent_rdata[ENT_W-1:VAL_W] == col_q);
	assign sts.search_done = !pend_q && (rd_idx_q == fill_q);
	assign sts.sweep_last  = sweep_q == ROW_AW'(ROWS - 1);
	assign sts.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_nz_q, out_fill_q, out_val_q, out_col_q};
	assign m_tuser  = {out_ob_q, out_status_q};

endmodule

FILE: rtl/sparse_row_scatter_accumulator_unit.sv
`timescale 1ns / 1ps
// Lower-triangle sparse matrix assembler: 1024 rows of up to 16 (column, Q16.16 value)
// entries. One word is in flight at a time. An insert searches the row's column ids,
// read from the single entry memory read port one per cycle, and stops at a match;
// an insert in the upper triangle returns without a search, and a read of an empty
// slot returns without an entry memory read. A clear sweeps the row-count memory one
// row a cycle; the same sweep runs after reset, during which no word is taken. A
// finished result sits in an output register, so the next word is taken while it
// waits.
module sparse_row_scatter_accumulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // row_index[9:0], col_index[19:10], add_value[51:20],
	                               // slot_index[55:52]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // entry_col[9:0], entry_value[41:10],
	                               // row_entries[46:42], total_nonzero[61:47]
	output logic [3:0]  m_tuser,   // status[2:0], over_bandwidth[3]
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata  // bandwidth_limit
);

	import srsa_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	srsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_cmd   (s_tuser),
		.s_tready (s_tready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	srsa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

`ifndef NO_ASSERTIONS
	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_push |-> (!m_tvalid || m_tready))
		else $error("result pushed over an untaken word");

	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.sweep_step |-> !s_tready)
		else $error("word taken during row-count sweep");

	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.sweep_step, dp_cmd.acc_write, dp_cmd.append_write, dp_cmd.ent_rd}))
		else $error("conflicting memory operations");

	a_push_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.res_load |=> !dp_cmd.res_load || dp_cmd.sweep_step)
		else $error("result overwritten before push");
`endif

endmodule
